>>> src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants, opcodes and header layout for the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // pool geometry
    localparam int POOL_GRANULES = 4096;
    localparam int IDX_W         = $clog2(POOL_GRANULES);
    localparam int LINK_W        = IDX_W + 1;

    // fixed field widths of the request and response words
    localparam int REQ_W = 12;
    localparam int OFS_W = 12;
    localparam int SUM_W = 12;

    // width that holds header index plus request plus one without overflow
    localparam int WIDE_W = ((LINK_W > REQ_W + 1) ? LINK_W : REQ_W + 1) + 1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    // one block header: data size in granules and link to next free header
    typedef struct packed {
        logic [LINK_W-1:0] size;
        logic [LINK_W-1:0] next;
    } hdr_t;

    localparam int HDR_W = 2 * LINK_W;

    localparam logic [LINK_W-1:0] LIST_END  = LINK_W'(POOL_GRANULES);
    localparam hdr_t              HDR_RESET = '{size: LINK_W'(POOL_GRANULES - 1),
                                                next: LINK_W'(POOL_GRANULES)};
    localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(POOL_GRANULES - 1);

endpackage

>>> src/ffpa_if.sv
// ----------------------------------------------------------------------------
// ffpa_if
// Valid/ready channels carrying allocator request and response words.
// ----------------------------------------------------------------------------
interface ffpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [ffpa_pkg::REQ_W-1:0]  request_granules;
    logic [ffpa_pkg::OFS_W-1:0]  release_offset;

    modport source (
        output valid,
        output opcode,
        output request_granules,
        output release_offset,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  request_granules,
        input  release_offset,
        output ready
    );
endinterface

interface ffpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [ffpa_pkg::OFS_W-1:0]  data_offset;
    logic [ffpa_pkg::SUM_W-1:0]  free_total;

    modport source (
        output valid,
        output status,
        output data_offset,
        output free_total,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  data_offset,
        input  free_total,
        output ready
    );
endinterface

>>> src/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/first_fit_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// First-fit free-list allocator over a granule pool kept in one header RAM.
// ----------------------------------------------------------------------------
// steps: query and no-op go straight to the result; free reads and pushes the header
//   (an ignored offset goes straight to the result); allocate reads and checks each
//   header on the walk, then writes the split tail, shrinks, unlinks and gives the result
// one word in flight at a time; the walk does one RAM read per header and ends after POOL_GRANULES headers
// output register lets a new word enter while the last result waits
// reset: async active low, list holds one block of the whole pool at header 0;
//   header 0 is served from a reset image until first written, no RAM clearing
module first_fit_pool_allocator_core (
    input  logic              clk,
    input  logic              rst_n,
    ffpa_req_if.sink          req,
    ffpa_rsp_if.source        rsp
);

    // one-hot sequencer states
    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_WALK_RD  = 8'b0000_0010,
        ST_WALK_CHK = 8'b0000_0100,
        ST_CUR_WR   = 8'b0000_1000,
        ST_LINK     = 8'b0001_0000,
        ST_PREV_WR  = 8'b0010_0000,
        ST_FREE_CHK = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    localparam int LINK_W = ffpa_pkg::LINK_W;
    localparam int IDX_W  = ffpa_pkg::IDX_W;
    localparam int WIDE_W = ffpa_pkg::WIDE_W;
    localparam int SUM_W  = ffpa_pkg::SUM_W;
    localparam int OFS_W  = ffpa_pkg::OFS_W;
    localparam int REQ_W  = ffpa_pkg::REQ_W;

    // control registers
    state_t                state_reg, state_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  e0_reg, e0_next;
    logic                  out_valid_reg, out_valid_next;

    // datapath registers
    logic [LINK_W-1:0]     cur_reg, cur_next;
    logic [LINK_W-1:0]     prev_reg, prev_next;
    logic [LINK_W-1:0]     link_reg, link_next;
    logic [LINK_W-1:0]     steps_reg, steps_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic                  rdz_reg, rdz_next;
    logic                  res_status_reg, res_status_next;
    logic [OFS_W-1:0]      res_offset_reg, res_offset_next;
    logic [SUM_W-1:0]      res_total_reg, res_total_next;
    logic                  out_status_reg, out_status_next;
    logic [OFS_W-1:0]      out_offset_reg, out_offset_next;
    logic [SUM_W-1:0]      out_total_reg, out_total_next;

    // header RAM ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    ffpa_pkg::hdr_t        ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ffpa_pkg::HDR_W-1:0] ram_rdata;

    ffpa_ram #(
        .WIDTH (ffpa_pkg::HDR_W),
        .DEPTH (ffpa_pkg::POOL_GRANULES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // header 0 reads from the reset image until it is first written
    ffpa_pkg::hdr_t hq;
    assign hq = (rdz_reg && !e0_reg) ? ffpa_pkg::HDR_RESET : ffpa_pkg::hdr_t'(ram_rdata);

    // fit and split arithmetic on the header just read
    logic [WIDE_W-1:0] size_w, req_w, split_w, ofs_w, rel_w;
    logic              fits, can_split, cur_ok, prev_ok, free_ok, steps_out;

    assign size_w    = WIDE_W'(hq.size);
    assign req_w     = WIDE_W'(req_reg);
    assign split_w   = WIDE_W'(cur_reg) + req_w + WIDE_W'(1);
    assign ofs_w     = WIDE_W'(cur_reg) + WIDE_W'(1);
    assign fits      = size_w >= req_w;
    assign can_split = (size_w > req_w + WIDE_W'(1)) &&
                       (split_w < WIDE_W'(ffpa_pkg::POOL_GRANULES));
    assign cur_ok    = cur_reg < ffpa_pkg::LIST_END;
    assign prev_ok   = prev_reg < ffpa_pkg::LIST_END;
    assign steps_out = steps_reg == LINK_W'(ffpa_pkg::POOL_GRANULES);

    // header index of a released block, valid only for a nonzero in-pool offset
    assign rel_w   = WIDE_W'(req.release_offset) - WIDE_W'(1);
    assign free_ok = (req.release_offset != '0) &&
                     (rel_w < WIDE_W'(ffpa_pkg::POOL_GRANULES));

    // handshakes
    assign req.ready       = state_reg == ST_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.data_offset = out_offset_reg;
    assign rsp.free_total  = out_total_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        sum_next        = sum_reg;
        e0_next         = e0_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        link_next       = link_reg;
        steps_next      = steps_reg;
        req_next        = req_reg;
        rdz_next        = rdz_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_total_next  = res_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg[IDX_W-1:0];
        ram_wdata       = '{size: hq.size, next: head_reg};
        ram_re          = 1'b0;
        ram_raddr       = cur_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_next        = req.request_granules;
                    res_status_next = 1'b0;
                    res_offset_next = '0;
                    res_total_next  = '0;
                    case (ffpa_pkg::opcode_t'(req.opcode))
                        ffpa_pkg::OP_ALLOC:
                        begin
                            cur_next   = head_reg;
                            prev_next  = ffpa_pkg::LIST_END;
                            steps_next = '0;
                            state_next = ST_WALK_RD;
                        end
                        ffpa_pkg::OP_FREE:
                        begin
                            if (free_ok)
                            begin
                                cur_next   = rel_w[LINK_W-1:0];
                                ram_re     = 1'b1;
                                ram_raddr  = rel_w[IDX_W-1:0];
                                rdz_next   = rel_w == '0;
                                state_next = ST_FREE_CHK;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        ffpa_pkg::OP_QUERY:
                        begin
                            res_total_next = sum_reg;
                            state_next     = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // issue the read of the current header or give up
            ST_WALK_RD:
            begin
                if (!cur_ok || steps_out)
                begin
                    res_status_next = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    rdz_next   = cur_reg == '0;
                    state_next = ST_WALK_CHK;
                end
            end

            // advance, or take the block and write its split tail
            ST_WALK_CHK:
            begin
                if (!fits)
                begin
                    prev_next  = cur_reg;
                    cur_next   = hq.next;
                    steps_next = steps_reg + LINK_W'(1);
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    res_offset_next = ofs_w[OFS_W-1:0];
                    if (can_split)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = split_w[IDX_W-1:0];
                        ram_wdata  = '{size: LINK_W'(size_w - req_w - WIDE_W'(1)),
                                       next: hq.next};
                        if (split_w == '0)
                        begin
                            e0_next = 1'b1;
                        end
                        link_next  = split_w[LINK_W-1:0];
                        sum_next   = sum_reg - SUM_W'(req_reg) - SUM_W'(1);
                        state_next = ST_CUR_WR;
                    end
                    else
                    begin
                        link_next  = hq.next;
                        sum_next   = sum_reg - SUM_W'(hq.size);
                        state_next = ST_LINK;
                    end
                end
            end

            // shrink the taken block to the request
            ST_CUR_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{size: LINK_W'(req_reg), next: link_reg};
                if (cur_reg == '0)
                begin
                    e0_next = 1'b1;
                end
                state_next = ST_LINK;
            end

            // unlink: move the head or read the predecessor for rewrite
            ST_LINK:
            begin
                if (prev_ok)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = prev_reg[IDX_W-1:0];
                    rdz_next   = prev_reg == '0;
                    state_next = ST_PREV_WR;
                end
                else
                begin
                    head_next  = link_reg;
                    state_next = ST_DONE;
                end
            end

            ST_PREV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = prev_reg[IDX_W-1:0];
                ram_wdata = '{size: hq.size, next: link_reg};
                if (prev_reg == '0)
                begin
                    e0_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            // push released block on the list head
            ST_FREE_CHK:
            begin
                ram_we    = 1'b1;
                ram_wdata = '{size: hq.size, next: head_reg};
                if (cur_reg == '0)
                begin
                    e0_next = 1'b1;
                end
                head_next  = cur_reg;
                sum_next   = sum_reg + SUM_W'(hq.size);
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;
        out_total_next  = out_total_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_offset_next = res_offset_reg;
            out_total_next  = res_total_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            sum_reg       <= ffpa_pkg::SUM_RESET;
            e0_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
            e0_reg        <= e0_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        link_reg       <= link_next;
        steps_reg      <= steps_next;
        req_reg        <= req_next;
        rdz_reg        <= rdz_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_total_reg  <= res_total_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
        out_total_reg  <= out_total_next;
    end

endmodule

>>> bench/ffpa_reply_checker.sv
// ----------------------------------------------------------------------------
// ffpa_reply_checker
// Watches both allocator channels. Every accepted request word runs through a
// first-fit pool predictor that keeps its own header store, list head and
// free sum. Every accepted response word is compared, field by field, against
// the oldest reply still due.
// ----------------------------------------------------------------------------
module ffpa_reply_checker
    import ffpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ffpa_req_if  req,
    ffpa_rsp_if  rsp,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             status;
        logic [OFS_W-1:0] data_offset;
        logic [SUM_W-1:0] free_total;
    } pool_reply_t;

    // predicted pool state
    logic [LINK_W-1:0] blk_size [POOL_GRANULES];
    logic [LINK_W-1:0] blk_link [POOL_GRANULES];
    logic [LINK_W-1:0] list_first;
    logic [SUM_W-1:0]  free_granules;

    pool_reply_t replies_due [$];
    int          mismatches;

    // one word against the predicted pool, returns the reply it must produce
    function automatic pool_reply_t apply_pool_op(logic [1:0] op, logic [REQ_W-1:0] want,
                                                  logic [OFS_W-1:0] rel);
        pool_reply_t r;
        int          cur;
        int          prev;
        int          steps;
        int          split_at;
        int          want_n;
        int          h;
        r = '0;
        case (opcode_t'(op))
            OP_ALLOC:
            begin
                want_n = int'(want);
                cur    = int'(list_first);
                prev   = POOL_GRANULES;
                steps  = 0;
                // first fit, walk bounded by the pool size so a cyclic list ends
                while (cur < POOL_GRANULES && int'(blk_size[cur]) < want_n
                       && steps < POOL_GRANULES)
                begin
                    prev  = cur;
                    cur   = int'(blk_link[cur]);
                    steps = steps + 1;
                end
                if (cur >= POOL_GRANULES || steps >= POOL_GRANULES)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    split_at = cur + 1 + want_n;
                    // split only when the tail holds a header and fits in the pool
                    if (int'(blk_size[cur]) > want_n + 1 && split_at < POOL_GRANULES)
                    begin
                        blk_size[split_at] = LINK_W'(int'(blk_size[cur]) - 1 - want_n);
                        blk_link[split_at] = blk_link[cur];
                        blk_size[cur]      = LINK_W'(want_n);
                        blk_link[cur]      = LINK_W'(split_at);
                        free_granules      = free_granules - SUM_W'(want_n + 1);
                    end
                    else
                    begin
                        free_granules = free_granules - SUM_W'(blk_size[cur]);
                    end
                    // unlink the chosen block
                    if (prev < POOL_GRANULES)
                        blk_link[prev] = blk_link[cur];
                    else
                        list_first = blk_link[cur];
                    r.data_offset = OFS_W'(cur + 1);
                end
            end
            OP_FREE:
            begin
                // offset zero is ignored, anything else is pushed at the head
                if (rel != '0)
                begin
                    h             = int'(rel) - 1;
                    blk_link[h]   = list_first;
                    list_first    = LINK_W'(h);
                    free_granules = free_granules + SUM_W'(blk_size[h]);
                end
            end
            OP_QUERY:
            begin
                r.free_total = free_granules;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // predict on request words, compare on response words
    always @(posedge clk or negedge rst_n)
    begin
        pool_reply_t got;
        pool_reply_t due;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_GRANULES; i++)
            begin
                blk_size[i] = '0;
                blk_link[i] = LIST_END;
            end
            blk_size[0]   = HDR_RESET.size;
            blk_link[0]   = HDR_RESET.next;
            list_first    = '0;
            free_granules = SUM_RESET;
            replies_due.delete();
            mismatches    = 0;
            fails        <= 0;
            pending      <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                replies_due.push_back(apply_pool_op(req.opcode, req.request_granules,
                                                    req.release_offset));
            if (rsp.valid && rsp.ready)
            begin
                got.status      = rsp.status;
                got.data_offset = rsp.data_offset;
                got.free_total  = rsp.free_total;
                if (replies_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: response word with no request outstanding: status %0d offset %0d sum %0d",
                                 $realtime, got.status, got.data_offset, got.free_total);
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (got.status !== due.status || got.data_offset !== due.data_offset
                        || got.free_total !== due.free_total)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected status %0d offset %0d sum %0d, got status %0d offset %0d sum %0d",
                                     $realtime, due.status, due.data_offset, due.free_total,
                                     got.status, got.data_offset, got.free_total);
                    end
                end
            end
            fails   <= mismatches;
            pending <= replies_due.size();
        end
    end

endmodule

>>> bench/tb_first_fit_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_first_fit_pool_allocator_core
// Stimulus and verdict for the first-fit pool allocator. A short directed run
// covers the pool extremes, the empty list, zero requests, ignored frees and
// no-ops. A random mix of allocates, frees of live blocks, queries and noise
// follows, with random gaps on both channels, one idle-free stretch and one
// long response hold-off. A closing run double-frees a block so that the
// list turns cyclic and the allocate walk has to hit its bound.
// ----------------------------------------------------------------------------
module tb_first_fit_pool_allocator_core;
    import ffpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 18;
    localparam int RANDOM_WORDS = 1280;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 650;
    localparam int HOLD_AFTER   = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIVE_MAX     = 64;
    // worst case is two bounded walks of a cyclic list plus every allocate
    // walking a long fragmented list under full back-pressure, taken a few times
    localparam int LIMIT_CYCLES = 5_000_000;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   cycle_count = 0;
    int   words_taken = 0;
    int   hold_left   = 0;
    bit   hold_done   = 1'b0;
    bit   calm;

    // data offsets handed out and not yet freed
    logic [OFS_W-1:0] held_offsets [$];

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    first_fit_pool_allocator_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ffpa_reply_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off, track handed-out offsets
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                words_taken = words_taken + 1;
                if (rsp_ch.data_offset != '0)
                    held_offsets.push_back(rsp_ch.data_offset);
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && words_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
        end
    end

    // offer one request word and wait for it to be taken
    task automatic send_word(opcode_t op, logic [REQ_W-1:0] want, logic [OFS_W-1:0] rel);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.opcode           <= op;
        req_ch.request_granules <= want;
        req_ch.release_offset   <= rel;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // free a live block, the newest or a random one
    task automatic free_held(input bit newest, output logic [OFS_W-1:0] ofs);
        int k;
        while (held_offsets.size() == 0)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        k   = newest ? held_offsets.size() - 1 : $urandom_range(held_offsets.size() - 1);
        ofs = held_offsets[k];
        held_offsets.delete(k);
        send_word(OP_FREE, REQ_W'($urandom), ofs);
    endtask

    initial
    begin
        logic [OFS_W-1:0] ofs;
        logic [REQ_W-1:0] want;
        int               pick;
        int               size_pick;
        calm         = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_NOP;
        req_ch.request_granules <= '0;
        req_ch.release_offset   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: whole pool, empty list, tight split, zero request, noise ops
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ALLOC, 12'hFFF, 12'hFFF);
        send_word(OP_QUERY, 12'hFFF, 12'hFFF);
        send_word(OP_ALLOC, '0, 12'hFFF);
        free_held(1'b1, ofs);
        send_word(OP_ALLOC, 12'd4093, '0);
        send_word(OP_ALLOC, '0, '0);
        free_held(1'b1, ofs);
        free_held(1'b1, ofs);
        send_word(OP_FREE, 12'hFFF, '0);
        send_word(OP_NOP, 12'hFFF, 12'hFFF);
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ALLOC, 12'hFFF, '0);
        send_word(OP_ALLOC, 12'd4094, '0);
        send_word(OP_ALLOC, 12'd2, '0);
        send_word(OP_ALLOC, 12'd1, '0);

        // random mix, mostly small requests so the list walks stay short
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = (n >= CALM_FROM && n < CALM_TO);
            pick = $urandom_range(99);
            if (held_offsets.size() > LIVE_MAX)
                pick = 60;
            if (pick < 42 || (pick < 78 && held_offsets.size() == 0))
            begin
                size_pick = $urandom_range(99);
                if (size_pick < 55)
                    want = REQ_W'($urandom_range(15));
                else if (size_pick < 85)
                    want = REQ_W'($urandom_range(127, 16));
                else if (size_pick < 95)
                    want = REQ_W'($urandom_range(1023, 128));
                else
                    want = REQ_W'($urandom_range(4095, 1024));
                send_word(OP_ALLOC, want, OFS_W'($urandom));
            end
            else if (pick < 78)
                free_held(1'b0, ofs);
            else if (pick < 88)
                send_word(OP_QUERY, REQ_W'($urandom), OFS_W'($urandom));
            else if (pick < 94)
                send_word(OP_NOP, REQ_W'($urandom), OFS_W'($urandom));
            else
                send_word(OP_FREE, REQ_W'($urandom), '0);
        end
        calm = 1'b0;

        // double free makes the list cyclic, allocate must stop at its walk bound
        free_held(1'b1, ofs);
        send_word(OP_FREE, REQ_W'($urandom), ofs);
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ALLOC, 12'hFFF, '0);
        send_word(OP_ALLOC, '0, '0);
        send_word(OP_QUERY, '0, '0);
        send_word(OP_ALLOC, 12'hFFF, '0);
        req_ch.valid <= 1'b0;

        // drain, then let the block settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
